/* hdl/rwts_pkg.sv */
package rwts_pkg;

  localparam int SCREEN_HEIGHT_DEF = 480;
  localparam int TEX_SIZE_DEF      = 64;

  localparam int DATA_W     = 32;
  localparam int MEM_DEPTH  = 16384;
  localparam int ADDR_W     = 14;
  localparam int SLOT_W     = 12;
  localparam int Q10_ONE    = 1024;
  localparam int TEX_IDX_W  = 6;
  localparam int CMDQ_DEPTH = 32;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_SHADE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    FACE_NORTH = 2'd0,
    FACE_SOUTH = 2'd1,
    FACE_WEST  = 2'd2,
    FACE_EAST  = 2'd3
  } face_e;

  typedef struct packed {
    op_e         operation;
    face_e       face;
    logic [11:0] texel_index;
    logic [31:0] texel_value;
    logic [19:0] distance;
    logic [19:0] hit_x;
    logic [19:0] hit_y;
    logic [9:0]  column;
    logic [9:0]  row;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  pixel_column;
    logic [9:0]  pixel_row;
    logic [31:0] pixel_color;
    logic        visible;
  } out_item_t;

  // Item as it travels down the front pipeline.
  typedef struct packed {
    op_e                  op;
    face_e                face;
    logic [11:0]          texel_index;
    logic [31:0]          texel_value;
    logic [9:0]           column;
    logic [9:0]           row;
    logic [TEX_IDX_W-1:0] texcol;
    logic                 visible;
  } front_side_t;

  // Memory command handed from the front to the back.
  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
    logic [9:0]        column;
    logic [9:0]        row;
    logic              visible;
  } cmd_t;

endpackage

/* hdl/rwts_fifo.sv */
module rwts_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  always_comb begin
    do_push  = push_i && (count_q != CW'(DEPTH));
    do_pop   = pop_i && (count_q != '0);
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(DEPTH));
  assign count_o = count_q;

endmodule

/* hdl/rwts_div.sv */
module rwts_div #(
  parameter int NW = 20,
  parameter int DW = 20,
  parameter int QW = 11,
  parameter int SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic          ovf_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  localparam int RW = (NW > DW + QW) ? NW : DW + QW;

  logic          v_q    [QW+1];
  logic          ovf_q  [QW+1];
  logic [RW-1:0] rem_q  [QW+1];
  logic [DW-1:0] den_q  [QW+1];
  logic [QW-1:0] quo_q  [QW+1];
  logic [SW-1:0] side_q [QW+1];

  // First stage: a quotient that needs more than QW bits is flagged here; the
  // remaining stages give a valid quotient only when num < den * 2^QW.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ovf_q[0]  <= RW'(num_i) >= (RW'(den_i) << QW);
    rem_q[0]  <= RW'(num_i);
    den_q[0]  <= den_i;
    quo_q[0]  <= '0;
    side_q[0] <= side_i;
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [RW-1:0] trial;
    logic          ge;

    always_comb begin
      trial = RW'(den_q[k-1]) << (QW - k);
      ge    = rem_q[k-1] >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      ovf_q[k]  <= ovf_q[k-1];
      rem_q[k]  <= ge ? rem_q[k-1] - trial : rem_q[k-1];
      den_q[k]  <= den_q[k-1];
      quo_q[k]  <= quo_q[k-1] | (QW'(ge) << (QW - k));
      side_q[k] <= side_q[k-1];
    end
  end

  assign valid_o = v_q[QW];
  assign ovf_o   = ovf_q[QW];
  assign quo_o   = quo_q[QW];
  assign side_o  = side_q[QW];

endmodule

/* hdl/rwts_front.sv */
module rwts_front #(
  parameter int SCREEN_HEIGHT = rwts_pkg::SCREEN_HEIGHT_DEF,
  parameter int TEX_SIZE      = rwts_pkg::TEX_SIZE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rwts_pkg::in_item_t item_i,
  output logic               full_o,
  output logic               cmd_valid_o,
  output rwts_pkg::cmd_t     cmd_o,
  input  logic               cmd_pop_i
);

  import rwts_pkg::*;

  localparam int HALF    = SCREEN_HEIGHT / 2;
  localparam int SIZE_QW = 11;
  localparam int ROW_QW  = $clog2(TEX_SIZE);
  localparam int SIDE_W  = $bits(front_side_t);
  localparam int CRED_W  = $clog2(CMDQ_DEPTH + 1);
  localparam logic [19:0]        SIZE_NUM = 20'(HALF * Q10_ONE);
  localparam logic signed [13:0] HALF_S   = 14'(HALF);
  localparam logic signed [13:0] H_S      = 14'(SCREEN_HEIGHT);

  // Items in the pipeline plus items in the command queue.
  logic [CRED_W-1:0] cred_q, cred_d;
  logic              accept;

  logic [10:0]          frac;
  logic [17:0]          tc_prod;
  logic [TEX_IDX_W-1:0] texcol;

  logic        s0_v_q;
  front_side_t s0_side_q;
  logic [19:0] s0_dist_q;

  logic               d1_v, d1_ovf;
  logic [SIZE_QW-1:0] d1_quo;
  logic [SIDE_W-1:0]  d1_side_w;
  front_side_t        d1_side;

  logic [10:0]        size;
  logic signed [13:0] sz_s, row_s, t_s, top_s, off_s;
  logic               on_slice;
  logic [10:0]        off_c;

  logic        m_v_q;
  front_side_t m_side_q, m_side_d;
  logic [17:0] m_num_q;
  logic [11:0] m_den_q;

  logic              d2_v, d2_ovf;
  logic [ROW_QW-1:0] d2_quo;
  logic [SIDE_W-1:0] d2_side_w;
  front_side_t       d2_side;

  logic [TEX_IDX_W-1:0] texrow;
  logic [SLOT_W-1:0]    slot_pos;

  logic cmd_valid_q;
  cmd_t cmd_q;

  always_comb begin
    accept = push_i && !full_o;
    cred_d = cred_q + CRED_W'(accept) - CRED_W'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cred_q <= '0;
    end else begin
      cred_q <= cred_d;
    end
  end

  assign full_o = (cred_q == CRED_W'(CMDQ_DEPTH));

  // Texture column from the fractional part of the hit coordinate.
  always_comb begin
    unique case (item_i.face)
      FACE_NORTH: frac = {1'b0, item_i.hit_x[9:0]};
      FACE_SOUTH: frac = (item_i.hit_x[9:0] == '0) ? '0 :
                         11'(Q10_ONE) - {1'b0, item_i.hit_x[9:0]};
      FACE_WEST:  frac = {1'b0, item_i.hit_y[9:0]};
      FACE_EAST:  frac = (item_i.hit_y[9:0] == '0) ? '0 :
                         11'(Q10_ONE) - {1'b0, item_i.hit_y[9:0]};
      default:    frac = '0;
    endcase
    tc_prod = 18'(frac) * 18'(TEX_SIZE);
    if (tc_prod[17:10] > 8'(TEX_SIZE - 1)) begin
      texcol = TEX_IDX_W'(TEX_SIZE - 1);
    end else begin
      texcol = tc_prod[10 +: TEX_IDX_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else begin
      s0_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_side_q.op          <= item_i.operation;
    s0_side_q.face        <= item_i.face;
    s0_side_q.texel_index <= item_i.texel_index;
    s0_side_q.texel_value <= item_i.texel_value;
    s0_side_q.column      <= item_i.column;
    s0_side_q.row         <= item_i.row;
    s0_side_q.texcol      <= texcol;
    s0_side_q.visible     <= 1'b0;
    s0_dist_q             <= item_i.distance;
  end

  // Slice half-height: (H/2 in Q10) / distance. A zero distance overflows.
  rwts_div #(
    .NW(20),
    .DW(20),
    .QW(SIZE_QW),
    .SW(SIDE_W)
  ) u_size_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s0_v_q),
    .num_i   (SIZE_NUM),
    .den_i   (s0_dist_q),
    .side_i  (s0_side_q),
    .valid_o (d1_v),
    .ovf_o   (d1_ovf),
    .quo_o   (d1_quo),
    .side_o  (d1_side_w)
  );

  assign d1_side = d1_side_w;

  // Visibility and the offset of the row from the top of the slice.
  always_comb begin
    if (d1_ovf || d1_quo > 11'(SCREEN_HEIGHT)) begin
      size = 11'(SCREEN_HEIGHT);
    end else begin
      size = d1_quo;
    end
    sz_s  = $signed({3'b0, size});
    row_s = $signed({4'b0, d1_side.row});
    t_s   = H_S - (sz_s <<< 1);
    // The arithmetic shift rounds down, so a negative value is bumped first to halve toward zero.
    top_s = (t_s + $signed({13'b0, t_s[13]})) >>> 1;
    off_s = row_s - top_s;
    off_c = off_s[13] ? '0 : off_s[10:0];
    on_slice = (size != '0) && (row_s > HALF_S - sz_s) && (row_s < HALF_S + sz_s) &&
               (row_s <= H_S - 14'sd1);
  end

  always_comb begin
    m_side_d         = d1_side;
    m_side_d.visible = (d1_side.op == OP_SHADE) && on_slice;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else begin
      m_v_q <= d1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    m_side_q <= m_side_d;
    m_num_q  <= 18'(off_c) * 18'(TEX_SIZE);
    m_den_q  <= {size, 1'b0};
  end

  rwts_div #(
    .NW(18),
    .DW(12),
    .QW(ROW_QW),
    .SW(SIDE_W)
  ) u_row_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m_v_q),
    .num_i   (m_num_q),
    .den_i   (m_den_q),
    .side_i  (m_side_q),
    .valid_o (d2_v),
    .ovf_o   (d2_ovf),
    .quo_o   (d2_quo),
    .side_o  (d2_side_w)
  );

  assign d2_side = d2_side_w;

  always_comb begin
    if (d2_ovf || 7'(d2_quo) > 7'(TEX_SIZE - 1)) begin
      texrow = TEX_IDX_W'(TEX_SIZE - 1);
    end else begin
      texrow = TEX_IDX_W'(d2_quo);
    end
    slot_pos = SLOT_W'(13'(texrow) * 13'(TEX_SIZE) + 13'(d2_side.texcol));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= d2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q.op      <= d2_side.op;
    cmd_q.addr    <= (d2_side.op == OP_LOAD) ? {d2_side.face, d2_side.texel_index} :
                                               {d2_side.face, slot_pos};
    cmd_q.wdata   <= d2_side.texel_value;
    cmd_q.column  <= d2_side.column;
    cmd_q.row     <= d2_side.row;
    cmd_q.visible <= d2_side.visible;
  end

  assign cmd_valid_o = cmd_valid_q;
  assign cmd_o       = cmd_q;

endmodule

/* hdl/rwts_back.sv */
module rwts_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  rwts_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output rwts_pkg::out_item_t result_o
);

  import rwts_pkg::*;

  localparam int OUT_DEPTH = 2;
  localparam int OCW       = $clog2(OUT_DEPTH + 1);

  logic [DATA_W-1:0] tex_mem [MEM_DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic              mem_v_q;
  cmd_t              mem_cmd_q;

  logic [OCW-1:0]            out_count;
  logic                      out_pop;
  logic                      take;
  out_item_t                 res_in;
  logic [$bits(out_item_t)-1:0] res_out;

  // A command is taken only when the result it will produce has a slot,
  // counting the one still in the memory read stage.
  always_comb begin
    out_pop = pop_i && !empty_o;
    take    = cmd_valid_i &&
              ((OCW + 1)'(out_count) + (OCW + 1)'(mem_v_q) <
               (OCW + 1)'(OUT_DEPTH) + (OCW + 1)'(out_pop));
  end

  assign cmd_pop_o = take;

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (cmd_i.op == OP_LOAD) begin
        tex_mem[cmd_i.addr] <= cmd_i.wdata;
      end
      rdata_q <= tex_mem[cmd_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_v_q <= 1'b0;
    end else begin
      mem_v_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      mem_cmd_q <= cmd_i;
    end
  end

  always_comb begin
    res_in.pixel_column = mem_cmd_q.column;
    res_in.pixel_row    = mem_cmd_q.row;
    res_in.pixel_color  = mem_cmd_q.visible ? rdata_q : '0;
    res_in.visible      = mem_cmd_q.visible;
  end

  rwts_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mem_v_q),
    .wdata_i (res_in),
    .pop_i   (out_pop),
    .rdata_o (res_out),
    .empty_o (empty_o),
    .full_o  (),
    .count_o (out_count)
  );

  assign result_o = res_out;

endmodule

/* hdl/raycast_wall_texel_shader_unit.sv */
// From the transfer in to the result shown, an item passes through the two
// bit-per-stage divider pipelines and the texture memory read.
// Throughput: one item per cycle while full is low; the texture memory port serves
// one load or one shade lookup each cycle while the output queue has room.
// Reset clears all control state and the queues; texture contents are kept
// undefined until written.
module raycast_wall_texel_shader_unit #(
  parameter int SCREEN_HEIGHT = rwts_pkg::SCREEN_HEIGHT_DEF,
  parameter int TEX_SIZE      = rwts_pkg::TEX_SIZE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  rwts_pkg::in_item_t  item_i,
  output logic                empty,
  input  logic                pop,
  output rwts_pkg::out_item_t result_o
);

  import rwts_pkg::*;

  logic                  f_cmd_valid;
  cmd_t                  f_cmd;
  logic                  q_empty;
  logic [$bits(cmd_t)-1:0] q_rdata;
  cmd_t                  q_cmd;
  logic                  b_cmd_pop;

  rwts_front #(
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .TEX_SIZE(TEX_SIZE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (item_i),
    .full_o      (full),
    .cmd_valid_o (f_cmd_valid),
    .cmd_o       (f_cmd),
    .cmd_pop_i   (b_cmd_pop)
  );

  rwts_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMDQ_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_cmd_valid),
    .wdata_i (f_cmd),
    .pop_i   (b_cmd_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty),
    .full_o  (),
    .count_o ()
  );

  assign q_cmd = q_rdata;

  rwts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (b_cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .result_o    (result_o)
  );

endmodule

/* hdl/rwts_checker.sv */
module rwts_checker #(
  parameter int SCREEN_HEIGHT = rwts_pkg::SCREEN_HEIGHT_DEF
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input rwts_pkg::out_item_t result_o
);

  // Straight out of reset nothing is waiting and the input side is open.
  a_reset_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> empty && !full)
    else $error("queues not clear after reset");

  // A shown result that is not taken stays as it is.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(result_o))
    else $error("waiting result changed");

  // Hidden pixels and load results carry no colour.
  a_hidden_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !result_o.visible |-> result_o.pixel_color == '0)
    else $error("colour on hidden pixel");

  // A visible pixel's row always lies on the screen.
  a_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && result_o.visible |-> 32'(result_o.pixel_row) < 32'(SCREEN_HEIGHT))
    else $error("visible pixel below the screen");

endmodule

bind raycast_wall_texel_shader_unit rwts_checker #(
  .SCREEN_HEIGHT(SCREEN_HEIGHT)
) u_checker (.*);

/* tb/sv/raycast_wall_texel_shader_unit_tb.sv */
module raycast_wall_texel_shader_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rwts_pkg::*;

  localparam int HEIGHT   = 480;
  localparam int TEX      = 64;
  localparam int HALF     = HEIGHT / 2;
  localparam int N_RANDOM = 1250;
  localparam int LIMIT    = 400000;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  item_i;
  logic      empty;
  logic      pop;
  out_item_t result_o;

  raycast_wall_texel_shader_unit #(
    .SCREEN_HEIGHT(HEIGHT),
    .TEX_SIZE     (TEX)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (item_i),
    .empty   (empty),
    .pop     (pop),
    .result_o(result_o)
  );

  in_item_t    pending_items[$];
  out_item_t   expected_pixels[$];
  logic [31:0] texel_mirror[MEM_DEPTH];
  bit          texel_loaded[MEM_DEPTH];
  int          error_count;
  int          cycle_count;
  int          push_gap;
  int          pop_gap;
  bit          burst_mode;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Works out whether a shade item hits the wall slice and which texel it reads.
  function automatic void locate_texel(input in_item_t it, output logic vis,
                                       output logic [ADDR_W-1:0] addr);
    int size, top, off, texrow, texcol, frac_x, frac_y, f;
    if (it.distance == 0) size = HEIGHT;
    else size = (HALF * Q10_ONE) / int'(it.distance);
    if (size > HEIGHT) size = HEIGHT;
    vis = size > 0 && int'(it.row) > HALF - size && int'(it.row) < HALF + size
          && int'(it.row) <= HEIGHT - 1;
    top = (HEIGHT - 2 * size) / 2;
    off = int'(it.row) - top;
    if (off < 0) off = 0;
    texrow = (size > 0) ? (off * TEX) / (2 * size) : 0;
    if (texrow > TEX - 1) texrow = TEX - 1;
    frac_x = int'(it.hit_x[9:0]);
    frac_y = int'(it.hit_y[9:0]);
    case (it.face)
      FACE_NORTH: f = frac_x;
      FACE_SOUTH: f = (frac_x != 0) ? Q10_ONE - frac_x : 0;
      FACE_WEST:  f = frac_y;
      default:    f = (frac_y != 0) ? Q10_ONE - frac_y : 0;
    endcase
    texcol = (f * TEX) >> 10;
    if (texcol > TEX - 1) texcol = TEX - 1;
    addr = ADDR_W'(int'(it.face) * 4096 + texrow * TEX + texcol);
  endfunction

  function automatic out_item_t shade_pixel(input in_item_t it);
    out_item_t res;
    logic vis;
    logic [ADDR_W-1:0] addr;
    res.pixel_column = it.column;
    res.pixel_row    = it.row;
    res.pixel_color  = '0;
    res.visible      = 1'b0;
    if (it.operation == OP_LOAD) begin
      texel_mirror[{it.face, it.texel_index}] = it.texel_value;
    end else begin
      locate_texel(it, vis, addr);
      if (vis) begin
        res.pixel_color = texel_mirror[addr];
        res.visible     = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic in_item_t random_fields();
    in_item_t it;
    it.operation   = op_e'($urandom_range(0, 1));
    it.face        = face_e'($urandom_range(0, 3));
    it.texel_index = 12'($urandom);
    it.texel_value = $urandom;
    it.distance    = 20'($urandom);
    it.hit_x       = 20'($urandom);
    it.hit_y       = 20'($urandom);
    it.column      = 10'($urandom);
    it.row         = 10'($urandom);
    return it;
  endfunction

  task automatic queue_load(input in_item_t it);
    it.operation = OP_LOAD;
    texel_loaded[{it.face, it.texel_index}] = 1'b1;
    pending_items.push_back(it);
  endtask

  // A visible shade whose texel was never loaded is preceded by a load of that texel.
  task automatic queue_shade(input in_item_t it);
    logic vis;
    logic [ADDR_W-1:0] addr;
    in_item_t ld;
    it.operation = OP_SHADE;
    locate_texel(it, vis, addr);
    if (vis && !texel_loaded[addr]) begin
      ld             = random_fields();
      ld.face        = face_e'(addr[13:12]);
      ld.texel_index = addr[11:0];
      queue_load(ld);
    end
    pending_items.push_back(it);
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push   <= 1'b0;
      item_i <= '0;
    end else if (push && !full) begin
      expected_pixels.push_back(shade_pixel(item_i));
      push_gap = burst_mode ? 0 : $urandom_range(0, 6);
      if (push_gap == 0 && pending_items.size() > 0) begin
        item_i <= pending_items.pop_front();
      end else begin
        push <= 1'b0;
      end
    end else if (!push) begin
      if (push_gap > 0) begin
        push_gap--;
      end else if (pending_items.size() > 0) begin
        item_i <= pending_items.pop_front();
        push   <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (pop && !empty) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        if (result_o.pixel_column !== expected_pixels[0].pixel_column)
          report_mismatch($sformatf("pixel_column %0d, expected %0d",
                          result_o.pixel_column, expected_pixels[0].pixel_column));
        if (result_o.pixel_row !== expected_pixels[0].pixel_row)
          report_mismatch($sformatf("pixel_row %0d, expected %0d",
                          result_o.pixel_row, expected_pixels[0].pixel_row));
        if (result_o.pixel_color !== expected_pixels[0].pixel_color)
          report_mismatch($sformatf("pixel_color %h, expected %h",
                          result_o.pixel_color, expected_pixels[0].pixel_color));
        if (result_o.visible !== expected_pixels[0].visible)
          report_mismatch($sformatf("visible %b, expected %b",
                          result_o.visible, expected_pixels[0].visible));
        void'(expected_pixels.pop_front());
      end
      pop_gap = burst_mode ? 0 : $urandom_range(0, 6);
      if (pop_gap != 0) pop <= 1'b0;
    end else if (!pop) begin
      if (pop_gap > 0) pop_gap--;
      else pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    int pick;
    error_count = 0;
    cycle_count = 0;
    push_gap    = 0;
    pop_gap     = 0;
    burst_mode  = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    item_i      = '0;
    rst_ni      = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: corner indexes, zero and extreme distances, fractions at
    // zero and at the top of the range, rows off the slice and off screen.
    for (int f = 0; f < 4; f++) begin
      it = random_fields();
      it.face = face_e'(f);
      it.texel_index = (f % 2 == 0) ? 12'd0 : 12'hfff;
      it.texel_value = (f % 2 == 0) ? 32'hffff_ffff : 32'h0;
      queue_load(it);
    end
    for (int k = 0; k < 14; k++) begin
      it = random_fields();
      it.face = face_e'(k % 4);
      case (k)
        0: begin it.distance = 20'd0; it.row = 10'd0; end
        1: begin it.distance = 20'd0; it.row = 10'd479; end
        2: begin it.distance = 20'd1; it.row = 10'd1023; end
        3: begin it.distance = 20'hfffff; it.row = 10'd240; end
        4: begin it.distance = 20'd1024; it.row = 10'd1; end
        5: begin it.distance = 20'd1024; it.row = 10'd240; it.hit_x = '0; it.hit_y = '0; end
        6: begin it.distance = 20'd512; it.row = 10'd479; it.hit_x = '1; it.hit_y = '1; end
        7: begin it.distance = 20'd1025; it.row = 10'd239; it.hit_x = 20'h3ff; end
        8: begin it.distance = 20'd256; it.row = 10'd480; end
        9: begin it.distance = 20'd2048; it.row = 10'd120; it.hit_y = 20'h400; end
        10: begin it.distance = 20'd2048; it.row = 10'd121; it.hit_y = 20'h401; end
        11: begin it.distance = 20'd3; it.row = 10'd300; it.column = '1; end
        12: begin it.distance = 20'd4096; it.row = 10'd250; it.column = '0; end
        default: begin it.distance = 20'd245761; it.row = 10'd240; end
      endcase
      queue_shade(it);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      it = random_fields();
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        queue_load(it);
      end else begin
        if (pick < 7) it.distance = 20'($urandom_range(200, 8192));
        else if (pick == 7) it.distance = 20'($urandom_range(0, 8));
        if (pick != 9) it.row = 10'($urandom_range(0, HEIGHT - 1));
        queue_shade(it);
      end
    end

    wait (pending_items.size() == 0 && !push);
    wait (expected_pixels.size() == 0);
    repeat (100) @(posedge clk_i);
    if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
